@@ rtl/mid_pkg.sv @@
// ============================================================================
// mid_pkg
// Shared types, codes and the opcode mask/compare table of the minicomputer
// instruction decoder.
// ============================================================================
package mid_pkg;

    localparam int ENTRY_COUNT = 41;
    localparam int HIT_W       = 6;

    localparam logic [3:0] FM_INVALID = 4'd0;
    localparam logic [3:0] FM_NONE    = 4'd1;
    localparam logic [3:0] FM_ONEACC  = 4'd2;
    localparam logic [3:0] FM_EA      = 4'd3;
    localparam logic [3:0] FM_ACCEA   = 4'd4;
    localparam logic [3:0] FM_IO      = 4'd5;
    localparam logic [3:0] FM_ALU     = 4'd6;
    localparam logic [3:0] FM_MAP     = 4'd7;
    localparam logic [3:0] FM_IOT     = 4'd8;
    localparam logic [3:0] FM_TRAP    = 4'd9;

    localparam logic [5:0] FL_NONE = 6'h00;
    localparam logic [5:0] FL_CODE = 6'h01;
    localparam logic [5:0] FL_END  = 6'h02;
    localparam logic [5:0] FL_SKIP = 6'h04;
    localparam logic [5:0] FL_IND  = 6'h08;
    localparam logic [5:0] FL_REF  = 6'h10;
    localparam logic [5:0] FL_RIP  = 6'h20;

    localparam logic [1:0] IDX_ZERO  = 2'd0;
    localparam logic [1:0] IDX_PCREL = 2'd1;

    localparam logic [2:0] SKIP_NONE = 3'd0;
    localparam logic [2:0] SKIP_SKP  = 3'd1;

    localparam logic [15:0] FILL_ZERO = 16'h0000;
    localparam logic [15:0] FILL_ONES = 16'hFFFF;

    localparam logic [15:0] MASK_TBL [ENTRY_COUNT] = '{
        16'hF800, 16'hF800, 16'hF800, 16'hF800, 16'hE000, 16'hE000,
        16'hFFFF, 16'hE7FF, 16'hE7FF, 16'hFFFF, 16'hE7FF, 16'hE7FF,
        16'hE7FF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFF00,
        16'hFF00, 16'hFF00, 16'hFF00, 16'hE700, 16'hE700, 16'hE7FF,
        16'hE7FF, 16'hE73F, 16'hE700, 16'hE73F, 16'hE700, 16'hE700,
        16'hE73F, 16'hE700, 16'h800F, 16'h8700, 16'h8700, 16'h8700,
        16'h8700, 16'h8700, 16'h8700, 16'h8700, 16'h8700
    };

    localparam logic [15:0] MATCH_TBL [ENTRY_COUNT] = '{
        16'h0000, 16'h0800, 16'h1000, 16'h1800, 16'h2000, 16'h4000,
        16'h607F, 16'h6001, 16'h6081, 16'h60BF, 16'h60FF, 16'h6201,
        16'h6281, 16'h6501, 16'h6581, 16'h7641, 16'h76C1, 16'h6000,
        16'h6700, 16'h6A00, 16'h7200, 16'h6100, 16'h6200, 16'h6301,
        16'h6381, 16'h633F, 16'h6300, 16'h643F, 16'h6400, 16'h6500,
        16'h663F, 16'h6600, 16'h8008, 16'h8000, 16'h8100, 16'h8200,
        16'h8300, 16'h8400, 16'h8500, 16'h8600, 16'h8700
    };

    localparam logic [3:0] FORM_TBL [ENTRY_COUNT] = '{
        FM_EA,     FM_EA,     FM_EA,     FM_EA,     FM_ACCEA,  FM_ACCEA,
        FM_NONE,   FM_ONEACC, FM_ONEACC, FM_NONE,   FM_MAP,    FM_ONEACC,
        FM_ONEACC, FM_NONE,   FM_NONE,   FM_NONE,   FM_NONE,   FM_IO,
        FM_IOT,    FM_IO,     FM_IO,     FM_IO,     FM_IO,     FM_ONEACC,
        FM_ONEACC, FM_IO,     FM_IO,     FM_IO,     FM_IO,     FM_IO,
        FM_IO,     FM_IO,     FM_TRAP,   FM_ALU,    FM_ALU,    FM_ALU,
        FM_ALU,    FM_ALU,    FM_ALU,    FM_ALU,    FM_ALU
    };

    localparam logic [5:0] FLAG_TBL [ENTRY_COUNT] = '{
        FL_REF | FL_CODE | FL_END, FL_REF | FL_CODE, FL_SKIP, FL_SKIP,
        FL_NONE, FL_NONE, FL_NONE, FL_NONE, FL_NONE, FL_NONE, FL_NONE,
        FL_NONE, FL_NONE, FL_NONE, FL_END,  FL_NONE, FL_NONE, FL_NONE,
        FL_SKIP, FL_NONE, FL_NONE, FL_NONE, FL_NONE, FL_NONE, FL_NONE,
        FL_NONE, FL_NONE, FL_NONE, FL_NONE, FL_NONE, FL_NONE, FL_NONE,
        FL_NONE, FL_NONE, FL_NONE, FL_NONE, FL_NONE, FL_NONE, FL_NONE,
        FL_NONE, FL_NONE
    };

    typedef struct packed {
        logic              valid_res;
        logic [5:0]        mnemonic;
        logic [3:0]        form;
        logic [1:0]        acc_source;
        logic [1:0]        acc_dest;
        logic [1:0]        index_mode;
        logic signed [7:0] displacement;
        logic [14:0]       target;
        logic [5:0]        device;
        logic [6:0]        modifiers;
        logic [2:0]        skip_cond;
        logic [5:0]        flow_flags;
    } res_t;

endpackage

@@ rtl/minicomputer_instruction_decoder_core.sv @@
// ============================================================================
// minicomputer_instruction_decoder_core
// Decodes one 16-bit minicomputer instruction word per transaction into
// mnemonic, form, operand fields and flow flags.
//
//   channel | direction | handshake           | payload
//   --------+-----------+---------------------+-------------------------------
//   in      | input     | in_valid / in_stall | instr_word .. byte_addr
//   out     | output    | out_valid/out_stall | valid_res .. flow_flags
//
// One transaction per cycle while out is not stalled; the path runs input register,
// table match and field extraction, result register.
// Reset clears both valid flags; payload registers are not reset.
// A stall on out holds the result register; the input register still fills,
// and in_stall rises only when both stages hold a transaction.
// ============================================================================
module minicomputer_instruction_decoder_core
    import mid_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [15:0]       instr_word,
    input  logic [15:0]       following_word,
    input  logic [15:0]       byte_addr,
    output logic              out_valid,
    input  logic              out_stall,
    output logic              valid_res,
    output logic [5:0]        mnemonic,
    output logic [3:0]        form,
    output logic [1:0]        acc_source,
    output logic [1:0]        acc_dest,
    output logic [1:0]        index_mode,
    output logic signed [7:0] displacement,
    output logic [14:0]       target,
    output logic [5:0]        device,
    output logic [6:0]        modifiers,
    output logic [2:0]        skip_cond,
    output logic [5:0]        flow_flags
);

    logic             s1_valid_reg;
    logic             s1_valid_next;
    logic [15:0]      s1_word_reg;
    logic [15:0]      s1_follow_reg;
    logic [15:0]      s1_addr_reg;
    logic             s2_valid_reg;
    logic             s2_valid_next;
    res_t             s2_res_reg;
    logic [HIT_W-1:0] hit;
    res_t             dec_res;
    logic             s2_load;
    logic             s1_load;

    assign s2_load  = s1_valid_reg && (!s2_valid_reg || !out_stall);
    assign in_stall = s1_valid_reg && !s2_load;
    assign s1_load  = in_valid && !in_stall;

    assign s1_valid_next = s1_load || (s1_valid_reg && !s2_load);
    assign s2_valid_next = s2_load || (s2_valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_load)
        begin
            s1_word_reg   <= instr_word;
            s1_follow_reg <= following_word;
            s1_addr_reg   <= byte_addr;
        end
        if (s2_load)
        begin
            s2_res_reg <= dec_res;
        end
    end

    mid_match u_match
    (
        .word (s1_word_reg),
        .hit  (hit)
    );

    mid_fields u_fields
    (
        .word      (s1_word_reg),
        .next_word (s1_follow_reg),
        .addr      (s1_addr_reg),
        .hit       (hit),
        .res       (dec_res)
    );

    assign out_valid    = s2_valid_reg;
    assign valid_res    = s2_res_reg.valid_res;
    assign mnemonic     = s2_res_reg.mnemonic;
    assign form         = s2_res_reg.form;
    assign acc_source   = s2_res_reg.acc_source;
    assign acc_dest     = s2_res_reg.acc_dest;
    assign index_mode   = s2_res_reg.index_mode;
    assign displacement = s2_res_reg.displacement;
    assign target       = s2_res_reg.target;
    assign device       = s2_res_reg.device;
    assign modifiers    = s2_res_reg.modifiers;
    assign skip_cond    = s2_res_reg.skip_cond;
    assign flow_flags   = s2_res_reg.flow_flags;

`ifndef SYNTH
    a_stall_needs_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (s1_valid_reg && s2_valid_reg && out_stall))
        else $error("in_stall raised with a free stage");

    a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
        s2_load |=> out_valid)
        else $error("loaded result not presented");

    a_mnem_valid: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((mnemonic != 6'd0) == valid_res) && ((form != FM_INVALID) == valid_res))
        else $error("mnemonic or form disagrees with valid_res");

    a_trap_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (form == FM_TRAP)) |-> (skip_cond == SKIP_NONE && index_mode == 2'd0
            && device == 6'd0))
        else $error("trap result carries foreign fields");
`endif

endmodule

@@ rtl/mid_match.sv @@
// ============================================================================
// mid_match
// Priority match of one instruction word against the opcode table; returns
// the one-based number of the first matching entry, zero when none matches.
// ============================================================================
module mid_match
    import mid_pkg::*;
(
    input  logic [15:0]      word,
    output logic [HIT_W-1:0] hit
);

    always_comb
    begin
        hit = '0;
        for (int i = ENTRY_COUNT - 1; i >= 0; i--)
        begin
            if ((word & MASK_TBL[i]) == MATCH_TBL[i])
            begin
                hit = HIT_W'(i + 1);
            end
        end
    end

endmodule

@@ rtl/mid_fields.sv @@
// ============================================================================
// mid_fields
// Operand field extraction by instruction form, target address and flow
// flags, including the rip-stop check on repeated fill words.
// ============================================================================
module mid_fields
    import mid_pkg::*;
(
    input  logic [15:0]      word,
    input  logic [15:0]      next_word,
    input  logic [15:0]      addr,
    input  logic [HIT_W-1:0] hit,
    output res_t             res
);

    logic [HIT_W-1:0] entry;
    logic [5:0]       fl;
    logic             ok;
    logic             rip;

    assign entry = hit - HIT_W'(1);
    assign ok    = (hit != '0) && !addr[0];
    assign rip   = ((word == FILL_ZERO) || (word == FILL_ONES)) && (next_word == word);

    always_comb
    begin
        res = '0;
        fl  = FL_NONE;
        if (ok)
        begin
            res.valid_res = 1'b1;
            res.mnemonic  = hit;
            res.form      = FORM_TBL[entry];
            fl            = FLAG_TBL[entry];
            case (res.form)
                FM_ONEACC, FM_MAP:
                begin
                    res.acc_dest = word[12:11];
                end
                FM_EA, FM_ACCEA:
                begin
                    if (res.form == FM_ACCEA)
                    begin
                        res.acc_dest = word[12:11];
                    end
                    if (word[10])
                    begin
                        fl = fl | FL_IND;
                    end
                    res.index_mode   = word[9:8];
                    res.displacement = word[7:0];
                    if (word[9:8] == IDX_ZERO)
                    begin
                        res.target = {7'd0, word[7:0]};
                        fl         = fl | FL_REF;
                    end
                    else if (word[9:8] == IDX_PCREL)
                    begin
                        res.target = addr[15:1] + {{7{word[7]}}, word[7:0]};
                        fl         = fl | FL_REF;
                    end
                end
                FM_IO:
                begin
                    res.acc_dest  = word[12:11];
                    res.device    = word[5:0];
                    res.modifiers = {5'd0, word[7:6]};
                end
                FM_IOT:
                begin
                    res.device    = word[5:0];
                    res.modifiers = {5'd0, word[7:6]};
                end
                FM_ALU:
                begin
                    res.acc_source = word[14:13];
                    res.acc_dest   = word[12:11];
                    res.modifiers  = {2'd0, word[3], word[7:6], word[5:4]};
                    res.skip_cond  = word[2:0];
                    if (word[2:0] != SKIP_NONE)
                    begin
                        fl = fl | FL_SKIP;
                    end
                    if (word[2:0] == SKIP_SKP)
                    begin
                        fl = fl | FL_END;
                    end
                end
                FM_TRAP:
                begin
                    res.acc_source = word[14:13];
                    res.acc_dest   = word[12:11];
                    res.modifiers  = word[10:4];
                end
                default:
                begin
                end
            endcase
        end
        if (rip)
        begin
            fl = fl | FL_RIP;
        end
        res.flow_flags = fl;
    end

endmodule

@@ test/minicomputer_instruction_decoder_core_test.sv @@
// ============================================================================
// minicomputer_instruction_decoder_core_test
// Self-checking bench for the 16-bit minicomputer instruction decoder. A
// decode ledger predicts every field of each result from the accepted
// instruction word, following word and byte address, and checks the results
// in order. The stimulus runs directed corner cases first, then a sweep over
// every opcode row, then random words. Both channels idle and stall at random,
// and one long output hold-off backs the pipeline up.
// ============================================================================
module minicomputer_instruction_decoder_core_test
    import mid_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_ITEMS = 1400;

    typedef struct packed {
        logic [15:0] mask;
        logic [15:0] pattern;
        logic [3:0]  form_code;
        logic [5:0]  flag_bits;
    } opcode_row_t;

    localparam opcode_row_t DECODE_ROWS [41] = '{
        '{16'hF800, 16'h0000, FM_EA,     FL_REF | FL_CODE | FL_END},
        '{16'hF800, 16'h0800, FM_EA,     FL_REF | FL_CODE},
        '{16'hF800, 16'h1000, FM_EA,     FL_SKIP},
        '{16'hF800, 16'h1800, FM_EA,     FL_SKIP},
        '{16'hE000, 16'h2000, FM_ACCEA,  FL_NONE},
        '{16'hE000, 16'h4000, FM_ACCEA,  FL_NONE},
        '{16'hFFFF, 16'h607F, FM_NONE,   FL_NONE},
        '{16'hE7FF, 16'h6001, FM_ONEACC, FL_NONE},
        '{16'hE7FF, 16'h6081, FM_ONEACC, FL_NONE},
        '{16'hFFFF, 16'h60BF, FM_NONE,   FL_NONE},
        '{16'hE7FF, 16'h60FF, FM_MAP,    FL_NONE},
        '{16'hE7FF, 16'h6201, FM_ONEACC, FL_NONE},
        '{16'hE7FF, 16'h6281, FM_ONEACC, FL_NONE},
        '{16'hFFFF, 16'h6501, FM_NONE,   FL_NONE},
        '{16'hFFFF, 16'h6581, FM_NONE,   FL_END},
        '{16'hFFFF, 16'h7641, FM_NONE,   FL_NONE},
        '{16'hFFFF, 16'h76C1, FM_NONE,   FL_NONE},
        '{16'hFF00, 16'h6000, FM_IO,     FL_NONE},
        '{16'hFF00, 16'h6700, FM_IOT,    FL_SKIP},
        '{16'hFF00, 16'h6A00, FM_IO,     FL_NONE},
        '{16'hFF00, 16'h7200, FM_IO,     FL_NONE},
        '{16'hE700, 16'h6100, FM_IO,     FL_NONE},
        '{16'hE700, 16'h6200, FM_IO,     FL_NONE},
        '{16'hE7FF, 16'h6301, FM_ONEACC, FL_NONE},
        '{16'hE7FF, 16'h6381, FM_ONEACC, FL_NONE},
        '{16'hE73F, 16'h633F, FM_IO,     FL_NONE},
        '{16'hE700, 16'h6300, FM_IO,     FL_NONE},
        '{16'hE73F, 16'h643F, FM_IO,     FL_NONE},
        '{16'hE700, 16'h6400, FM_IO,     FL_NONE},
        '{16'hE700, 16'h6500, FM_IO,     FL_NONE},
        '{16'hE73F, 16'h663F, FM_IO,     FL_NONE},
        '{16'hE700, 16'h6600, FM_IO,     FL_NONE},
        '{16'h800F, 16'h8008, FM_TRAP,   FL_NONE},
        '{16'h8700, 16'h8000, FM_ALU,    FL_NONE},
        '{16'h8700, 16'h8100, FM_ALU,    FL_NONE},
        '{16'h8700, 16'h8200, FM_ALU,    FL_NONE},
        '{16'h8700, 16'h8300, FM_ALU,    FL_NONE},
        '{16'h8700, 16'h8400, FM_ALU,    FL_NONE},
        '{16'h8700, 16'h8500, FM_ALU,    FL_NONE},
        '{16'h8700, 16'h8600, FM_ALU,    FL_NONE},
        '{16'h8700, 16'h8700, FM_ALU,    FL_NONE}
    };

    // word, following word, byte address
    localparam logic [47:0] CORNER_WORDS [24] = '{
        {16'h0000, 16'h0000, 16'h0000},
        {16'hFFFF, 16'hFFFF, 16'hFFFF},
        {16'hFFFF, 16'hFFFE, 16'h1234},
        {16'hFFFF, 16'hFFFF, 16'h0002},
        {16'h0000, 16'hFFFF, 16'h0002},
        {16'h0580, 16'h0000, 16'h0000},
        {16'h0A05, 16'h0000, 16'h0100},
        {16'h1300, 16'h5555, 16'h0200},
        {16'h18FF, 16'hAAAA, 16'hFFFE},
        {16'h2D7F, 16'h0000, 16'hFFFE},
        {16'h5C80, 16'h0000, 16'h8000},
        {16'h4001, 16'h0000, 16'h0001},
        {16'h607F, 16'h0000, 16'h0010},
        {16'h6581, 16'h0000, 16'h0012},
        {16'h7641, 16'h0000, 16'h0014},
        {16'h6800, 16'h0000, 16'h0016},
        {16'h6F00, 16'h0000, 16'h0018},
        {16'h6600, 16'h0000, 16'h001A},
        {16'h67C0, 16'h0000, 16'h001C},
        {16'h78FF, 16'h0000, 16'h001E},
        {16'hFFF8, 16'h0000, 16'h0020},
        {16'h8008, 16'h0000, 16'h0022},
        {16'h8001, 16'h0000, 16'h0024},
        {16'h87FF, 16'h0000, 16'h0026}
    };

    class decode_ledger;
        res_t pending_decodes[$];
        int   mismatches;

        function new();
            mismatches = 0;
        endfunction

        function res_t predict_decode(logic [15:0] w, logic [15:0] nxt, logic [15:0] addr);
            res_t r;
            int   hit;
            r   = '0;
            hit = -1;
            for (int i = 0; i < 41; i++)
                if (hit < 0 && (w & DECODE_ROWS[i].mask) == DECODE_ROWS[i].pattern)
                    hit = i;
            if (hit >= 0 && !addr[0])
            begin
                r.valid_res  = 1'b1;
                r.mnemonic   = 6'(hit + 1);
                r.form       = DECODE_ROWS[hit].form_code;
                r.flow_flags = DECODE_ROWS[hit].flag_bits;
                case (r.form)
                    FM_ONEACC, FM_MAP:
                        r.acc_dest = w[12:11];
                    FM_EA, FM_ACCEA:
                    begin
                        if (r.form == FM_ACCEA)
                            r.acc_dest = w[12:11];
                        if (w[10])
                            r.flow_flags |= FL_IND;
                        r.index_mode   = w[9:8];
                        r.displacement = w[7:0];
                        if (w[9:8] == IDX_ZERO)
                        begin
                            r.target      = {7'd0, w[7:0]};
                            r.flow_flags |= FL_REF;
                        end
                        else if (w[9:8] == IDX_PCREL)
                        begin
                            r.target      = addr[15:1] + {{7{w[7]}}, w[7:0]};
                            r.flow_flags |= FL_REF;
                        end
                    end
                    FM_IO:
                    begin
                        r.acc_dest  = w[12:11];
                        r.device    = w[5:0];
                        r.modifiers = {5'd0, w[7:6]};
                    end
                    FM_IOT:
                    begin
                        r.device    = w[5:0];
                        r.modifiers = {5'd0, w[7:6]};
                    end
                    FM_ALU:
                    begin
                        r.acc_source = w[14:13];
                        r.acc_dest   = w[12:11];
                        r.modifiers  = {2'd0, w[3], w[7:6], w[5:4]};
                        r.skip_cond  = w[2:0];
                        if (w[2:0] != SKIP_NONE)
                            r.flow_flags |= FL_SKIP;
                        if (w[2:0] == SKIP_SKP)
                            r.flow_flags |= FL_END;
                    end
                    FM_TRAP:
                    begin
                        r.acc_source = w[14:13];
                        r.acc_dest   = w[12:11];
                        r.modifiers  = w[10:4];
                    end
                    default:
                        ;
                endcase
            end
            if ((w == FILL_ZERO || w == FILL_ONES) && nxt == w)
                r.flow_flags |= FL_RIP;
            return r;
        endfunction

        function void note_instr(logic [15:0] w, logic [15:0] nxt, logic [15:0] addr);
            pending_decodes.push_back(predict_decode(w, nxt, addr));
        endfunction

        function void compare_field(string name, logic [15:0] exp_v, logic [15:0] got_v);
            if (got_v !== exp_v)
            begin
                $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, got_v);
                mismatches++;
            end
        endfunction

        function void check_result(res_t got);
            res_t exp_r;
            if (pending_decodes.size() == 0)
            begin
                $error("result transaction with no decode pending");
                mismatches++;
                return;
            end
            exp_r = pending_decodes.pop_front();
            compare_field("valid_res", 16'(exp_r.valid_res), 16'(got.valid_res));
            compare_field("mnemonic", 16'(exp_r.mnemonic), 16'(got.mnemonic));
            compare_field("form", 16'(exp_r.form), 16'(got.form));
            compare_field("acc_source", 16'(exp_r.acc_source), 16'(got.acc_source));
            compare_field("acc_dest", 16'(exp_r.acc_dest), 16'(got.acc_dest));
            compare_field("index_mode", 16'(exp_r.index_mode), 16'(got.index_mode));
            compare_field("displacement", {8'd0, exp_r.displacement},
                          {8'd0, got.displacement});
            compare_field("target", 16'(exp_r.target), 16'(got.target));
            compare_field("device", 16'(exp_r.device), 16'(got.device));
            compare_field("modifiers", 16'(exp_r.modifiers), 16'(got.modifiers));
            compare_field("skip_cond", 16'(exp_r.skip_cond), 16'(got.skip_cond));
            compare_field("flow_flags", 16'(exp_r.flow_flags), 16'(got.flow_flags));
        endfunction
    endclass

    logic              clk = 1'b0;
    logic              rst_n;
    logic              in_valid;
    logic              in_stall;
    logic [15:0]       instr_word;
    logic [15:0]       following_word;
    logic [15:0]       byte_addr;
    logic              out_valid;
    logic              out_stall;
    logic              valid_res;
    logic [5:0]        mnemonic;
    logic [3:0]        form;
    logic [1:0]        acc_source;
    logic [1:0]        acc_dest;
    logic [1:0]        index_mode;
    logic signed [7:0] displacement;
    logic [14:0]       target;
    logic [5:0]        device;
    logic [6:0]        modifiers;
    logic [2:0]        skip_cond;
    logic [5:0]        flow_flags;

    decode_ledger ledger = new;
    int           items_sent = 0;
    int           sender_calm_left = 0;
    bit           long_hold = 1'b0;

    minicomputer_instruction_decoder_core dut (.*);

    always #2 clk = ~clk;

    function automatic int pick_idle();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic send_instr(logic [15:0] w, logic [15:0] nxt, logic [15:0] addr);
        int gap;
        if (sender_calm_left > 0)
        begin
            sender_calm_left--;
            gap = 0;
        end
        else
        begin
            gap = pick_idle();
            if ($urandom_range(0, 39) == 0)
                sender_calm_left = $urandom_range(40, 120);
        end
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid       <= 1'b1;
        instr_word     <= w;
        following_word <= nxt;
        byte_addr      <= addr;
        do
            @(posedge clk);
        while (in_stall);
        ledger.note_instr(w, nxt, addr);
        items_sent++;
    endtask

    initial
    begin
        int          row;
        int          sel;
        logic [15:0] w;
        logic [15:0] nxt;
        logic [15:0] addr;
        rst_n          <= 1'b0;
        in_valid       <= 1'b0;
        instr_word     <= '0;
        following_word <= '0;
        byte_addr      <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (CORNER_WORDS[i])
            send_instr(CORNER_WORDS[i][47:32], CORNER_WORDS[i][31:16], CORNER_WORDS[i][15:0]);

        for (row = 0; row < 41; row++)
            send_instr((16'($urandom) & ~DECODE_ROWS[row].mask) | DECODE_ROWS[row].pattern,
                       16'($urandom), 16'($urandom) & 16'hFFFE);

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            sel = $urandom_range(0, 99);
            if (sel < 65)
            begin
                row = $urandom_range(0, 40);
                w   = (16'($urandom) & ~DECODE_ROWS[row].mask) | DECODE_ROWS[row].pattern;
            end
            else if (sel < 75)
                w = 16'($urandom);
            else if (sel < 85)
                w = $urandom_range(0, 1) ? FILL_ONES : FILL_ZERO;
            else
                w = {3'b011, 13'($urandom)};
            nxt = ($urandom_range(0, 2) == 0) ? w : 16'($urandom);
            case ($urandom_range(0, 19))
                0: addr = 16'h0000;
                1: addr = 16'hFFFE;
                2: addr = 16'hFFFF;
                3: addr = 16'($urandom) | 16'h0001;
                default: addr = 16'($urandom) & 16'hFFFE;
            endcase
            send_instr(w, nxt, addr);
        end
        in_valid <= 1'b0;

        while (ledger.pending_decodes.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (ledger.mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    initial
    begin
        int   stall_left;
        int   run_left;
        res_t seen;
        stall_left = 0;
        run_left   = 0;
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (out_valid === 1'b1 && !out_stall)
            begin
                seen = {valid_res, mnemonic, form, acc_source, acc_dest, index_mode,
                        displacement, target, device, modifiers, skip_cond, flow_flags};
                ledger.check_result(seen);
            end
            if (stall_left == 0 && run_left == 0)
            begin
                stall_left = pick_idle();
                run_left   = ($urandom_range(0, 11) == 0) ? $urandom_range(40, 120)
                                                           : $urandom_range(1, 6);
            end
            if (long_hold)
                out_stall <= 1'b1;
            else if (stall_left > 0)
            begin
                stall_left--;
                out_stall <= 1'b1;
            end
            else
            begin
                run_left--;
                out_stall <= 1'b0;
            end
        end
    end

    // hold the output off long enough for the pipeline to fill and stall its input
    initial
    begin
        wait (items_sent >= 500);
        @(negedge clk);
        long_hold = 1'b1;
        repeat (300) @(negedge clk);
        long_hold = 1'b0;
    end

    initial
    begin
        #3_500_000;
        $display("Some tests failed");
        $finish;
    end

endmodule
